// ----- design/hky_pkg.sv -----
package hky_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_FREQ_T = 3'd0,
    REG_FREQ_C = 3'd1,
    REG_FREQ_A = 3'd2,
    REG_FREQ_G = 3'd3,
    REG_KAPPA  = 3'd4
  } cfg_reg_t;

  localparam int STATES        = 4;
  localparam int ITEM_CYCLES   = 16;
  localparam int HORNER_TERMS  = 14;
  localparam int POW_STEPS     = 20;
  localparam int EXP_STAGES    = 2 * HORNER_TERMS;
  localparam int EXP_LAT       = EXP_STAGES + POW_STEPS + 3;
  localparam int X_Q_BITS      = 23;
  localparam int P_Q_BITS      = 17;
  localparam int ENT_LAST      = 5 + P_Q_BITS;

  localparam logic [22:0] XCLAMP   = 23'h40_0000;
  localparam logic [31:0] ONE31    = 32'h8000_0000;
  localparam logic [16:0] P_ONE    = 17'h1_0000;
  localparam logic [15:0] KAPPA_LO = 16'd256;

  // ceil(2^36 / k): exact floor(v / k) for v below 2^32 as (v * m) >> 36
  function automatic logic [35:0] recip_m(input int k);
    logic [35:0] m;
    case (k)
      2:       m = 36'd34359738368;
      3:       m = 36'd22906492246;
      4:       m = 36'd17179869184;
      5:       m = 36'd13743895348;
      6:       m = 36'd11453246123;
      7:       m = 36'd9817068106;
      8:       m = 36'd8589934592;
      9:       m = 36'd7635497416;
      10:      m = 36'd6871947674;
      11:      m = 36'd6247225158;
      12:      m = 36'd5726623062;
      13:      m = 36'd5286113596;
      14:      m = 36'd4908534053;
      default: m = 36'd0;
    endcase
    return m;
  endfunction

  // Horner series for exp(-f), Q0.31, worked out at elaboration
  function automatic logic [31:0] exp_frac_const(input logic [31:0] f31);
    logic [127:0] inner;
    logic [127:0] v;
    logic [127:0] d;
    int k;
    inner = 128'(ONE31);
    for (k = HORNER_TERMS; k >= 1; k--) begin
      v = (128'(f31) * inner) >> 31;
      if (k == 1) begin
        d = v;
      end else begin
        d = (v * 128'(recip_m(k))) >> 36;
      end
      inner = (d > 128'(ONE31)) ? 128'd0 : 128'(ONE31) - d;
    end
    return inner[31:0];
  endfunction

  localparam logic [31:0] EXP_M1 = exp_frac_const(ONE31);

  // Exponential pipeline stage contents
  typedef struct packed {
    logic [6:0]  n;
    logic [30:0] f;
    logic [31:0] acc;
  } exp_stage_t;

  typedef struct packed {
    logic [6:0]  n;
    logic [31:0] r;
  } exp_pow_t;

  // Branch-length scaling divider stage
  typedef struct packed {
    logic        bad;
    logic        sat;
    logic [63:0] rem;
    logic [22:0] q;
    logic [49:0] d;
    logic [33:0] a0;
    logic [33:0] a1;
  } fdiv_t;

  // Matrix entry pipeline stage
  typedef struct packed {
    logic        bad;
    logic        last;
    logic [1:0]  from_st;
    logic [1:0]  to_st;
    logic        same;
    logic        diag;
    logic [32:0] fjp;
    logic [32:0] fjo;
    logic [39:0] fme;
    logic [39:0] oth;
    logic [24:0] e1;
    logic [40:0] den;
    logic [56:0] t1;
    logic [16:0] othp;
    logic [57:0] base;
    logic [55:0] rig;
    logic [59:0] rem;
    logic        sat;
    logic [16:0] q;
  } ent_t;

endpackage

// ----- design/hky_exp_neg.sv -----
module hky_exp_neg (
  input  logic        clk,
  input  logic [22:0] x,
  output logic [24:0] e
);

  hky_pkg::exp_stage_t h_r [0:hky_pkg::EXP_STAGES];
  hky_pkg::exp_pow_t   p_r [0:hky_pkg::POW_STEPS];
  logic [24:0]         e_r;

  // split into integer part and Q0.31 fraction
  always_ff @(posedge clk) begin
    h_r[0] <= '{n: x[22:16], f: {x[15:0], 15'd0}, acc: hky_pkg::ONE31};
  end

  // Horner steps: truncated product, then quotient by the term index
  for (genvar h = 0; h < hky_pkg::HORNER_TERMS; h++) begin : g_horner
    localparam int          K = hky_pkg::HORNER_TERMS - h;
    localparam logic [35:0] M = hky_pkg::recip_m(K);
    logic [63:0] prod;
    logic [67:0] qprod;
    logic [31:0] quo;

    assign prod  = 64'(h_r[2*h].f) * 64'(h_r[2*h].acc);
    assign qprod = 68'(h_r[2*h+1].acc) * 68'(M);
    assign quo   = (K == 1) ? h_r[2*h+1].acc : qprod[67:36];

    always_ff @(posedge clk) begin
      h_r[2*h+1] <= '{n: h_r[2*h].n, f: h_r[2*h].f, acc: prod[62:31]};
      h_r[2*h+2] <= '{n: h_r[2*h+1].n, f: h_r[2*h+1].f, acc: hky_pkg::ONE31 - quo};
    end
  end

  always_ff @(posedge clk) begin
    p_r[0] <= '{n: h_r[hky_pkg::EXP_STAGES].n, r: h_r[hky_pkg::EXP_STAGES].acc};
  end

  // multiply by exp(-1) once for each whole unit of the exponent
  for (genvar s = 0; s < hky_pkg::POW_STEPS; s++) begin : g_pow
    logic [63:0] pp;
    assign pp = 64'(p_r[s].r) * 64'(hky_pkg::EXP_M1) + 64'(1 << 30);
    always_ff @(posedge clk) begin
      p_r[s+1].n <= p_r[s].n;
      p_r[s+1].r <= (7'(s) < p_r[s].n) ? pp[62:31] : p_r[s].r;
    end
  end

  // round to Q0.24; past the last step the value has already decayed to zero
  always_ff @(posedge clk) begin
    if (p_r[hky_pkg::POW_STEPS].n > 7'(hky_pkg::POW_STEPS)) begin
      e_r <= '0;
    end else begin
      e_r <= 25'((33'(p_r[hky_pkg::POW_STEPS].r) + 33'd64) >> 7);
    end
  end

  assign e = e_r;

endmodule

// ----- design/hky_transition_probabilities_unit.sv -----
// HKY85 transition probability matrix generator.
// Configuration: write freq_t, freq_c, freq_a, freq_g (index 0..3, Q0.16)
// and kappa (index 4, Q8.8) on the cfg_ channel; cfg_ready is always high.
// Write only while no request is in flight.
// Input: a request is taken at a rising edge with start high and busy low;
// in_branch_length is the branch length in Q8.16.
// Output: sixteen results on consecutive cycles, marked by out_valid, rows
// and columns in the order T,C,A,G, out_last on the sixteenth.
// Requests overlap: busy stays high after each accept while the cool-down
// counter runs down, spacing requests by one matrix on the single shared
// result channel. Up to eight requests are in flight at once in the pipeline.
// Reset clears the valid bits and restores the register defaults; the
// receiver cannot stall, so every result is shown for exactly one cycle.
module hky_transition_probabilities_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [23:0] in_branch_length,
  output logic        out_valid,
  output logic [1:0]  out_from_state,
  output logic [1:0]  out_to_state,
  output logic [16:0] out_probability,
  output logic        out_bad_config,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] freq_t_r, freq_c_r, freq_a_r, freq_g_r, kappa_r;
  logic [3:0]  cool_r;
  logic        accept;
  logic [16:0] sum_y, sum_r;
  logic [15:0] k_eff, k_m1;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign busy      = (cool_r != 4'd0);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_t_r <= 16'd6554;
      freq_c_r <= 16'd26214;
      freq_a_r <= 16'd13107;
      freq_g_r <= 16'd19661;
      kappa_r  <= 16'd2048;
    end else if (cfg_valid && cfg_ready) begin
      unique case (hky_pkg::cfg_reg_t'(cfg_index))
        hky_pkg::REG_FREQ_T: freq_t_r <= cfg_data;
        hky_pkg::REG_FREQ_C: freq_c_r <= cfg_data;
        hky_pkg::REG_FREQ_A: freq_a_r <= cfg_data;
        hky_pkg::REG_FREQ_G: freq_g_r <= cfg_data;
        hky_pkg::REG_KAPPA:  kappa_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // space requests by one matrix
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cool_r <= '0;
    end else if (accept) begin
      cool_r <= 4'(hky_pkg::ITEM_CYCLES - 1);
    end else if (cool_r != 4'd0) begin
      cool_r <= cool_r - 4'd1;
    end
  end

  assign sum_y = 17'(freq_t_r) + 17'(freq_c_r);
  assign sum_r = 17'(freq_a_r) + 17'(freq_g_r);
  assign k_eff = (kappa_r < hky_pkg::KAPPA_LO) ? hky_pkg::KAPPA_LO : kappa_r;
  assign k_m1  = k_eff - hky_pkg::KAPPA_LO;

  // ---------------- front end: exponent arguments ----------------
  logic        v0_r, v1_r, v2_r, v3_r;
  logic [23:0] t0_r, t1_r, t2_r;
  logic [33:0] ps1_r;
  logic [32:0] pq1_r;
  logic [33:0] a0_1_r, a1_1_r, a0_2_r, a1_2_r, a0_3_r, a1_3_r;
  logic        bad1_r, bad2_r, bad3_r;
  logic [49:0] d2_r, d3_r;
  logic [63:0] n3_r;

  // hold the branch length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= accept;
    end
    if (accept) begin
      t0_r <= in_branch_length;
    end
  end

  // class products and scale factors
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    t1_r   <= t0_r;
    ps1_r  <= 34'(sum_y) * 34'(sum_r);
    pq1_r  <= 33'(32'(freq_t_r) * 32'(freq_c_r)) + 33'(32'(freq_a_r) * 32'(freq_g_r));
    a0_1_r <= 34'(1 << 24) + 34'(33'(sum_y) * 33'(k_m1));
    a1_1_r <= 34'(1 << 24) + 34'(33'(sum_r) * 33'(k_m1));
    bad1_r <= (sum_y == 17'd0) || (sum_r == 17'd0);
    // denominator of beta
    t2_r   <= t1_r;
    d2_r   <= 50'({ps1_r, 8'd0}) + 50'(49'(k_eff) * 49'(pq1_r));
    a0_2_r <= a0_1_r;
    a1_2_r <= a1_1_r;
    bad2_r <= bad1_r;
    // rounded dividend
    n3_r   <= 64'({t2_r, 39'd0}) + 64'(d2_r >> 1);
    d3_r   <= d2_r;
    a0_3_r <= a0_2_r;
    a1_3_r <= a1_2_r;
    bad3_r <= bad2_r;
  end

  // restoring divider, one quotient bit per stage
  hky_pkg::fdiv_t dv_r  [0:hky_pkg::X_Q_BITS];
  logic           dvv_r [0:hky_pkg::X_Q_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvv_r[0] <= 1'b0;
    end else begin
      dvv_r[0] <= v3_r;
    end
    dv_r[0] <= '{bad: bad3_r,
                 sat: (73'(n3_r) >= (73'(d3_r) << hky_pkg::X_Q_BITS)),
                 rem: n3_r, q: '0, d: d3_r, a0: a0_3_r, a1: a1_3_r};
  end

  for (genvar j = 1; j <= hky_pkg::X_Q_BITS; j++) begin : g_xdiv
    localparam int B = hky_pkg::X_Q_BITS - j;
    hky_pkg::fdiv_t dstep_nxt;
    logic [72:0]    sh;

    always_comb begin
      dstep_nxt = dv_r[j-1];
      sh        = 73'(dv_r[j-1].d) << B;
      if (!dv_r[j-1].sat && (73'(dv_r[j-1].rem) >= sh)) begin
        dstep_nxt.rem  = 64'(73'(dv_r[j-1].rem) - sh);
        dstep_nxt.q[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dvv_r[j] <= 1'b0;
      end else begin
        dvv_r[j] <= dvv_r[j-1];
      end
      dv_r[j] <= dstep_nxt;
    end
  end

  // clamp, scale per class, clamp again
  logic        vx_r, vm_r, vr_r;
  logic        badx_r, badm_r, badr_r;
  logic [22:0] x1x_r, x1m_r, x1r_r;
  logic [33:0] a0x_r, a1x_r;
  logic [56:0] m0_r, m1_r;
  logic [22:0] x20_r, x21_r;
  logic [33:0] r0, r1;
  hky_pkg::fdiv_t dlast;

  assign dlast = dv_r[hky_pkg::X_Q_BITS];
  assign r0    = 34'((58'(m0_r) + 58'(1 << 23)) >> 24);
  assign r1    = 34'((58'(m1_r) + 58'(1 << 23)) >> 24);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vx_r <= 1'b0;
      vm_r <= 1'b0;
      vr_r <= 1'b0;
    end else begin
      vx_r <= dvv_r[hky_pkg::X_Q_BITS];
      vm_r <= vx_r;
      vr_r <= vm_r;
    end
    x1x_r  <= (dlast.sat || (dlast.q > hky_pkg::XCLAMP)) ? hky_pkg::XCLAMP : dlast.q;
    a0x_r  <= dlast.a0;
    a1x_r  <= dlast.a1;
    badx_r <= dlast.bad;
    m0_r   <= 57'(x1x_r) * 57'(a0x_r);
    m1_r   <= 57'(x1x_r) * 57'(a1x_r);
    x1m_r  <= x1x_r;
    badm_r <= badx_r;
    x20_r  <= (r0 > 34'(hky_pkg::XCLAMP)) ? hky_pkg::XCLAMP : r0[22:0];
    x21_r  <= (r1 > 34'(hky_pkg::XCLAMP)) ? hky_pkg::XCLAMP : r1[22:0];
    x1r_r  <= x1m_r;
    badr_r <= badm_r;
  end

  // exponentials
  logic [24:0] e1_w, e20_w, e21_w;

  hky_exp_neg u_exp_e1  (.clk(clk), .x(x1r_r), .e(e1_w));
  hky_exp_neg u_exp_e20 (.clk(clk), .x(x20_r), .e(e20_w));
  hky_exp_neg u_exp_e21 (.clk(clk), .x(x21_r), .e(e21_w));

  // carry valid and error flag alongside the exponentials
  logic sv_r [0:hky_pkg::EXP_LAT-1];
  logic sb_r [0:hky_pkg::EXP_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r[0] <= 1'b0;
    end else begin
      sv_r[0] <= vr_r;
    end
    sb_r[0] <= badr_r;
  end

  for (genvar s = 1; s < hky_pkg::EXP_LAT; s++) begin : g_sv
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[s] <= 1'b0;
      end else begin
        sv_r[s] <= sv_r[s-1];
      end
      sb_r[s] <= sb_r[s-1];
    end
  end

  // ---------------- entry sequencer ----------------
  logic        fv;
  logic        run_r;
  logic [3:0]  cnt_r;
  logic [24:0] e1h_r, e20h_r, e21h_r;
  logic        badh_r;

  assign fv = sv_r[hky_pkg::EXP_LAT-1];

  // step through the sixteen entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (fv) begin
      run_r <= 1'b1;
      cnt_r <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + 4'd1;
      if (cnt_r == 4'(hky_pkg::ITEM_CYCLES - 1)) begin
        run_r <= 1'b0;
      end
    end
    if (fv) begin
      e1h_r  <= e1_w;
      e20h_r <= e20_w;
      e21h_r <= e21_w;
      badh_r <= sb_r[hky_pkg::EXP_LAT-1];
    end
  end

  logic [1:0]    row, col;
  logic [15:0]   fj, fm;
  logic [16:0]   pc, oc;
  logic [24:0]   e2s;
  hky_pkg::ent_t e0_nxt;

  assign row = cnt_r[3:2];
  assign col = cnt_r[1:0];
  assign pc  = row[1] ? sum_r : sum_y;
  assign oc  = row[1] ? sum_y : sum_r;
  assign e2s = row[1] ? e21h_r : e20h_r;

  // pick column frequency and the partner of the row
  always_comb begin
    case (col)
      2'd0:    fj = freq_t_r;
      2'd1:    fj = freq_c_r;
      2'd2:    fj = freq_a_r;
      default: fj = freq_g_r;
    endcase
    case (row ^ 2'd1)
      2'd0:    fm = freq_t_r;
      2'd1:    fm = freq_c_r;
      2'd2:    fm = freq_a_r;
      default: fm = freq_g_r;
    endcase
  end

  // first products of each entry
  always_comb begin
    e0_nxt         = '0;
    e0_nxt.bad     = badh_r;
    e0_nxt.last    = (cnt_r == 4'(hky_pkg::ITEM_CYCLES - 1));
    e0_nxt.from_st = row;
    e0_nxt.to_st   = col;
    e0_nxt.same    = (row[1] == col[1]);
    e0_nxt.diag    = (row == col);
    e0_nxt.fjp     = 33'(fj) * 33'(pc);
    e0_nxt.fjo     = 33'(fj) * 33'(oc);
    e0_nxt.fme     = 40'(fm) * 40'(e2s);
    e0_nxt.oth     = 40'(fj) * 40'(25'(1 << 24) - e1h_r);
    e0_nxt.e1      = e1h_r;
    e0_nxt.den     = 41'({pc, 24'd0});
  end

  // ---------------- entry pipeline ----------------
  hky_pkg::ent_t ep_r [0:hky_pkg::ENT_LAST];
  logic          ev_r [0:hky_pkg::ENT_LAST];
  hky_pkg::ent_t e1_nxt, e2_nxt, e3_nxt, e4_nxt, e5_nxt;

  always_comb begin
    // weighted first exponential, other-class result
    e1_nxt      = ep_r[0];
    e1_nxt.t1   = 57'(58'(ep_r[0].fjo) * 58'(ep_r[0].e1));
    e1_nxt.othp = 17'((41'(ep_r[0].oth) + 41'(1 << 23)) >> 24);
    // align terms
    e2_nxt      = ep_r[1];
    e2_nxt.base = 58'({ep_r[1].fjp, 24'd0}) + 58'(ep_r[1].t1);
    e2_nxt.rig  = {ep_r[1].fme, 16'd0};
    // add or subtract the second exponential term, floor at zero
    e3_nxt      = ep_r[2];
    if (ep_r[2].diag) begin
      e3_nxt.rem = 60'(ep_r[2].base) + 60'(ep_r[2].rig);
    end else if (58'(ep_r[2].rig) > ep_r[2].base) begin
      e3_nxt.rem = '0;
    end else begin
      e3_nxt.rem = 60'(ep_r[2].base - 58'(ep_r[2].rig));
    end
    // add half the divisor for rounding
    e4_nxt      = ep_r[3];
    e4_nxt.rem  = ep_r[3].rem + 60'(ep_r[3].den >> 1);
    // detect a quotient beyond the divider range
    e5_nxt      = ep_r[4];
    e5_nxt.sat  = (ep_r[4].rem >= (60'(ep_r[4].den) << hky_pkg::P_Q_BITS));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_r[0] <= 1'b0;
      ev_r[1] <= 1'b0;
      ev_r[2] <= 1'b0;
      ev_r[3] <= 1'b0;
      ev_r[4] <= 1'b0;
      ev_r[5] <= 1'b0;
    end else begin
      ev_r[0] <= run_r;
      ev_r[1] <= ev_r[0];
      ev_r[2] <= ev_r[1];
      ev_r[3] <= ev_r[2];
      ev_r[4] <= ev_r[3];
      ev_r[5] <= ev_r[4];
    end
    ep_r[0] <= e0_nxt;
    ep_r[1] <= e1_nxt;
    ep_r[2] <= e2_nxt;
    ep_r[3] <= e3_nxt;
    ep_r[4] <= e4_nxt;
    ep_r[5] <= e5_nxt;
  end

  // divide by the class sum, one quotient bit per stage
  for (genvar j = 1; j <= hky_pkg::P_Q_BITS; j++) begin : g_pdiv
    localparam int B = hky_pkg::P_Q_BITS - j;
    hky_pkg::ent_t pstep_nxt;
    logic [59:0]   sh;

    always_comb begin
      pstep_nxt = ep_r[4+j];
      sh        = 60'(ep_r[4+j].den) << B;
      if (!ep_r[4+j].sat && (ep_r[4+j].rem >= sh)) begin
        pstep_nxt.rem  = ep_r[4+j].rem - sh;
        pstep_nxt.q[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ev_r[5+j] <= 1'b0;
      end else begin
        ev_r[5+j] <= ev_r[4+j];
      end
      ep_r[5+j] <= pstep_nxt;
    end
  end

  // result register
  hky_pkg::ent_t fin;
  logic          out_valid_r;
  logic [1:0]    out_from_r, out_to_r;
  logic [16:0]   out_prob_r;
  logic          out_bad_r, out_last_r;
  logic [16:0]   prob_nxt;

  assign fin = ep_r[hky_pkg::ENT_LAST];

  always_comb begin
    if (fin.bad) begin
      prob_nxt = '0;
    end else if (!fin.same) begin
      prob_nxt = fin.othp;
    end else if (fin.sat || (fin.q > hky_pkg::P_ONE)) begin
      prob_nxt = hky_pkg::P_ONE;
    end else begin
      prob_nxt = fin.q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ev_r[hky_pkg::ENT_LAST];
    end
    out_from_r <= fin.from_st;
    out_to_r   <= fin.to_st;
    out_prob_r <= prob_nxt;
    out_bad_r  <= fin.bad;
    out_last_r <= fin.last;
  end

  assign out_valid       = out_valid_r;
  assign out_from_state  = out_from_r;
  assign out_to_state    = out_to_r;
  assign out_probability = out_prob_r;
  assign out_bad_config  = out_bad_r;
  assign out_last        = out_last_r;

  // entries of one matrix leave on consecutive cycles
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("matrix burst broken");

  // an accepted request blocks the next one
  a_space: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request spacing lost");

  // a bad configuration always gives zero
  a_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_config |-> out_probability == 17'd0)
    else $error("nonzero probability on bad configuration");

  // the sequencer stops after the sixteenth entry
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    run_r && cnt_r == 4'd15 && !fv |=> !run_r)
    else $error("entry sequencer overran");

  // last marks the bottom-right entry
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_from_state == 2'd3 && out_to_state == 2'd3)
    else $error("last flag on wrong entry");

endmodule

// ----- tb/hky_transition_probabilities_unit_test.sv -----
module hky_transition_probabilities_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 130;
  localparam int CYCLE_LIMIT  = 300000;

  typedef enum int { CHK_MODEL, CHK_IDENTITY, CHK_ZERO } row_chk_t;

  typedef struct {
    bit                 is_cfg;
    hky_pkg::cfg_reg_t  idx;
    logic [15:0]        data;
    logic [23:0]        blen;
    row_chk_t           chk;
  } stim_row_t;

  typedef struct packed {
    logic [1:0]  from_st;
    logic [1:0]  to_st;
    logic [16:0] prob;
    logic        bad;
    logic        last;
  } entry_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [23:0] in_branch_length = '0;
  logic        out_valid;
  logic [1:0]  out_from_state;
  logic [1:0]  out_to_state;
  logic [16:0] out_probability;
  logic        out_bad_config;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  entry_t      matrix_q[$];
  int          errors = 0;
  int          cycles = 0;
  int          idle_pct = 0;
  logic [15:0] freq[4];
  logic [15:0] kappa_reg;

  hky_transition_probabilities_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_branch_length(in_branch_length),
    .out_valid(out_valid), .out_from_state(out_from_state),
    .out_to_state(out_to_state), .out_probability(out_probability),
    .out_bad_config(out_bad_config), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Guard against a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // exp(-f) for f in Q0.31 by truncated Horner series
  function automatic logic [63:0] exp_series(input logic [63:0] f31);
    logic [63:0] inner;
    logic [63:0] d;
    inner = 64'd1 << 31;
    for (int k = hky_pkg::HORNER_TERMS; k >= 1; k--) begin
      d = ((f31 * inner) >> 31) / k;
      inner = (d > (64'd1 << 31)) ? 64'd0 : (64'd1 << 31) - d;
    end
    return inner;
  endfunction

  // exp(-x) for x in Q16.16, result in Q0.24
  function automatic logic [63:0] decay(input logic [63:0] x16);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] e;
    n = x16 >> 16;
    r = exp_series((x16 & 64'hFFFF) << 15);
    e = exp_series(64'd1 << 31);
    for (int i = 0; i < n && r != 0; i++) r = (r * e + (64'd1 << 30)) >> 31;
    return (r + 64) >> 7;
  endfunction

  // Work out the sixteen matrix entries for one branch length
  task automatic predict_matrix(input logic [23:0] blen);
    logic [63:0] f[4];
    logic [63:0] csum[2];
    logic [63:0] e1[2];
    logic [63:0] e2[2];
    logic [63:0] k, d, x1, a, x2, pc, oc, fm, base, rig, num, den, p;
    logic        bad;
    entry_t      ent;
    for (int s = 0; s < 4; s++) f[s] = freq[s];
    k = (kappa_reg < hky_pkg::KAPPA_LO) ? 64'd256 : kappa_reg;
    csum[0] = f[0] + f[1];
    csum[1] = f[2] + f[3];
    bad = (csum[0] == 0 || csum[1] == 0);
    if (!bad) begin
      d = ((csum[0] * csum[1]) << 8) + k * (f[0] * f[1] + f[2] * f[3]);
      x1 = ((64'(blen) << 39) + (d >> 1)) / d;
      if (x1 > (64'd64 << 16)) x1 = 64'd64 << 16;
      for (int c = 0; c < 2; c++) begin
        a = (64'd1 << 24) + csum[c] * (k - 256);
        x2 = (x1 * a + (64'd1 << 23)) >> 24;
        if (x2 > (64'd64 << 16)) x2 = 64'd64 << 16;
        e1[c] = decay(x1);
        e2[c] = decay(x2);
      end
    end
    for (int i = 0; i < hky_pkg::STATES; i++) begin
      for (int j = 0; j < hky_pkg::STATES; j++) begin
        p = 0;
        if (!bad) begin
          if ((i >> 1) == (j >> 1)) begin
            pc = csum[i >> 1];
            oc = csum[(i >> 1) ^ 1];
            fm = f[i ^ 1];
            base = ((f[j] * pc) << 24) + f[j] * oc * e1[i >> 1];
            rig = (fm * e2[i >> 1]) << 16;
            den = pc << 24;
            if (i == j) num = base + rig;
            else num = (rig > base) ? 64'd0 : base - rig;
            p = (num + (den >> 1)) / den;
          end else begin
            p = (f[j] * ((64'd1 << 24) - e1[i >> 1]) + (64'd1 << 23)) >> 24;
          end
          if (p > 65536) p = 65536;
        end
        ent.from_st = i[1:0];
        ent.to_st = j[1:0];
        ent.prob = p[16:0];
        ent.bad = bad;
        ent.last = (i == hky_pkg::STATES - 1 && j == hky_pkg::STATES - 1);
        matrix_q.push_back(ent);
      end
    end
  endtask

  // Typed expectation for a directed row
  task automatic push_fixed(input row_chk_t chk);
    entry_t ent;
    for (int i = 0; i < hky_pkg::STATES; i++) begin
      for (int j = 0; j < hky_pkg::STATES; j++) begin
        ent.from_st = i[1:0];
        ent.to_st = j[1:0];
        ent.prob = (chk == CHK_IDENTITY && i == j) ? hky_pkg::P_ONE : 17'd0;
        ent.bad = (chk == CHK_ZERO);
        ent.last = (i == hky_pkg::STATES - 1 && j == hky_pkg::STATES - 1);
        matrix_q.push_back(ent);
      end
    end
  endtask

  // Send one request, holding start until accepted
  task automatic send_request(input logic [23:0] blen, input row_chk_t chk);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    in_branch_length <= blen;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (chk == CHK_MODEL) predict_matrix(blen);
    else push_fixed(chk);
  endtask

  // Drain the pipeline, then write one register
  task automatic write_reg(input hky_pkg::cfg_reg_t idx, input logic [15:0] data);
    start <= 1'b0;
    @(posedge clk);
    while (matrix_q.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == hky_pkg::REG_KAPPA) kappa_reg = data;
    else freq[idx] = data;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Check each result against the oldest expected entry
  always @(posedge clk) begin
    entry_t got;
    entry_t want;
    if (rst_n && out_valid) begin
      got = {out_from_state, out_to_state, out_probability, out_bad_config, out_last};
      if (matrix_q.size() == 0) begin
        $display("%0t: unexpected result from=%0d to=%0d prob=%0d bad=%0b last=%0b",
                 $time, out_from_state, out_to_state, out_probability,
                 out_bad_config, out_last);
        errors++;
      end else begin
        want = matrix_q.pop_front();
        if (got.from_st !== want.from_st || got.to_st !== want.to_st ||
            got.prob !== want.prob || got.bad !== want.bad || got.last !== want.last) begin
          $display("%0t: mismatch expected from=%0d to=%0d prob=%0d bad=%0b last=%0b",
                   $time, want.from_st, want.to_st, want.prob, want.bad, want.last);
          $display("%0t:          actual   from=%0d to=%0d prob=%0d bad=%0b last=%0b",
                   $time, got.from_st, got.to_st, got.prob, got.bad, got.last);
          errors++;
        end
      end
    end
  end

  stim_row_t directed[] = '{
    '{0, hky_pkg::REG_FREQ_T, 16'd0, 24'h000000, CHK_IDENTITY},
    '{0, hky_pkg::REG_FREQ_T, 16'd0, 24'h000001, CHK_MODEL},
    '{0, hky_pkg::REG_FREQ_T, 16'd0, 24'h010000, CHK_MODEL},
    '{0, hky_pkg::REG_FREQ_T, 16'd0, 24'h555555, CHK_MODEL},
    '{0, hky_pkg::REG_FREQ_T, 16'd0, 24'hAAAAAA, CHK_MODEL},
    '{0, hky_pkg::REG_FREQ_T, 16'd0, 24'hFFFFFF, CHK_MODEL},
    '{1, hky_pkg::REG_KAPPA,  16'd0, 24'h0, CHK_MODEL},
    '{0, hky_pkg::REG_FREQ_T, 16'd0, 24'h008000, CHK_MODEL},
    '{1, hky_pkg::REG_KAPPA,  16'd255, 24'h0, CHK_MODEL},
    '{0, hky_pkg::REG_FREQ_T, 16'd0, 24'h000000, CHK_IDENTITY},
    '{1, hky_pkg::REG_KAPPA,  16'hFFFF, 24'h0, CHK_MODEL},
    '{0, hky_pkg::REG_FREQ_T, 16'd0, 24'h010000, CHK_MODEL},
    '{0, hky_pkg::REG_FREQ_T, 16'd0, 24'h000000, CHK_IDENTITY},
    '{1, hky_pkg::REG_FREQ_T, 16'd0, 24'h0, CHK_MODEL},
    '{1, hky_pkg::REG_FREQ_C, 16'd0, 24'h0, CHK_MODEL},
    '{0, hky_pkg::REG_FREQ_T, 16'd0, 24'h001234, CHK_ZERO},
    '{1, hky_pkg::REG_FREQ_T, 16'hFFFF, 24'h0, CHK_MODEL},
    '{1, hky_pkg::REG_FREQ_C, 16'hFFFF, 24'h0, CHK_MODEL},
    '{1, hky_pkg::REG_FREQ_A, 16'hFFFF, 24'h0, CHK_MODEL},
    '{1, hky_pkg::REG_FREQ_G, 16'hFFFF, 24'h0, CHK_MODEL},
    '{0, hky_pkg::REG_FREQ_T, 16'd0, 24'h004000, CHK_MODEL},
    '{1, hky_pkg::REG_FREQ_A, 16'd0, 24'h0, CHK_MODEL},
    '{1, hky_pkg::REG_FREQ_G, 16'd0, 24'h0, CHK_MODEL},
    '{0, hky_pkg::REG_FREQ_T, 16'd0, 24'hFFFFFF, CHK_ZERO}
  };

  initial begin
    logic [23:0] blen;
    freq = '{16'd6554, 16'd26214, 16'd13107, 16'd19661};
    kappa_reg = 16'd2048;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests, defaults first
    foreach (directed[r]) begin
      if (directed[r].is_cfg) write_reg(directed[r].idx, directed[r].data);
      else send_request(directed[r].blen, directed[r].chk);
    end

    // Random phases: each gets a fresh setting and an idling rate from a repeating set
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 62;
        2: idle_pct = 15;
        default: idle_pct = 62;
      endcase
      for (int s = 0; s < 4; s++) begin
        case ($urandom_range(9))
          0: write_reg(hky_pkg::cfg_reg_t'(s), 16'd0);
          1: write_reg(hky_pkg::cfg_reg_t'(s), 16'hFFFF);
          2, 3, 4: write_reg(hky_pkg::cfg_reg_t'(s), 16'($urandom_range(1000, 30000)));
          default: write_reg(hky_pkg::cfg_reg_t'(s), 16'($urandom));
        endcase
      end
      case ($urandom_range(3))
        0: write_reg(hky_pkg::REG_KAPPA, 16'($urandom_range(0, 300)));
        1: write_reg(hky_pkg::REG_KAPPA, 16'hFFFF);
        default: write_reg(hky_pkg::REG_KAPPA, 16'($urandom));
      endcase
      for (int n = 0; n < 20; n++) begin
        blen = 24'($urandom);
        // Mostly short branches, where the matrix is far from equilibrium
        if ($urandom_range(3) != 0) blen = blen >> $urandom_range(4, 20);
        send_request(blen, CHK_MODEL);
      end
    end

    // Drain and let the pipeline settle
    start <= 1'b0;
    @(posedge clk);
    while (matrix_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
